[rtl/core/pcwd_pkg.sv]
// ----------------------------------------------------------------------------
// pcwd_pkg: shared types and codes for the paged chunk work distributor
// Request and response payloads, command, status and register index codes.
// ----------------------------------------------------------------------------
package pcwd_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_CLAIM  = 2'd1,
		CMD_SKIP   = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_READER = 3'd1,
		ST_NO_CHUNK   = 3'd2,
		ST_SKIP_IGN   = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	localparam logic [7:0] REG_CHUNK_PAGES  = 8'd0;
	localparam logic [7:0] REG_READER_COUNT = 8'd1;

	localparam logic [15:0] CHUNK_PAGES_RESET  = 16'd16;
	localparam logic [4:0]  READER_COUNT_RESET = 5'd1;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         reader_sel;
		logic signed [31:0] seq_page_count;
		logic [7:0]         seq_index;
		logic signed [31:0] run_last_page;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  chunk_seq;
		logic [30:0] chunk_start;
		logic [15:0] chunk_count;
		logic [39:0] reader_total;
		logic [39:0] claimed_total;
	} rsp_t;

endpackage

[rtl/core/paged_chunk_work_distributor_core.sv]
// ----------------------------------------------------------------------------
// paged_chunk_work_distributor_core: hands page chunks of sequences to readers
// Keeps per-sequence page counts, a chunk prefix table and reader tallies in
// RAM, and serves append, claim, skip and query requests one at a time.
// ----------------------------------------------------------------------------
// One request is processed at a time; the block takes a new request as soon
// as the previous one has moved into the response register, even if that
// response has not been taken yet. An append and a skip each wait on the
// bit-serial 32 by 16 divider that computes chunk counts. A claim runs a
// binary search over the prefix table RAM of at most ceil(log2(MAX_SEQS+1))
// steps, 7 for 64 sequences, each step a read of that RAM followed by a
// compare. A query and a claim with no chunk left skip the search, and a
// rejected request goes straight to the response. A response that is still
// waiting to be taken holds the next one back until it is taken. Chunk sizes
// are fixed into the prefix table at append time; claims use the current
// chunk size. Reader tallies start at zero after reset through per-reader
// valid bits, so no clearing pass is run. Configuration writes are always
// accepted and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module paged_chunk_work_distributor_core #(
	parameter int MAX_SEQS    = 64,
	parameter int MAX_READERS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            req_valid,
	output logic            req_ready,
	input  pcwd_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pcwd_pkg::rsp_t  rsp
);

	// Address widths of the three memories and of the sequence count.
	localparam int SL_W = $clog2(MAX_SEQS + 1);
	localparam int SA_W = MAX_SEQS > 1 ? $clog2(MAX_SEQS) : 1;
	localparam int RA_W = MAX_READERS > 1 ? $clog2(MAX_READERS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_TRD, S_BS_ISSUE, S_BS_CMP, S_PG, S_MUL, S_CNT,
		S_SK_A, S_SK_B, S_SK_C, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] chunk_pages_q;
	logic [4:0]  reader_count_q;

	// Architectural state outside the memories.
	logic [SL_W-1:0]        seq_loaded_q;
	logic [39:0]            total_q;
	logic [39:0]            cursor_q;
	logic [MAX_READERS-1:0] tvalid_q;

	// Per-request working registers.
	pcwd_pkg::req_t  req_q;
	pcwd_pkg::rsp_t  res_q;
	pcwd_pkg::rsp_t  rsp_q;
	logic            rsp_valid_q;
	logic [15:0]     cp_q;
	logic [RA_W-1:0] ra_q;
	logic [39:0]     g_q;
	logic [39:0]     tally_q;
	logic [SL_W-1:0] lo_q;
	logic [SL_W-1:0] hi_q;
	logic [39:0]     base_q;
	logic [39:0]     local_q;
	logic [30:0]     pages_q;
	logic [47:0]     start_q;
	logic [39:0]     p0_q;
	logic [39:0]     p1_q;
	logic            pf_zero_q;

	// Memory ports.
	logic            sp_we;
	logic [SA_W-1:0] sp_waddr;
	logic [30:0]     sp_wdata;
	logic [30:0]     sp_rdata;
	logic            pf_we;
	logic [SL_W-1:0] pf_waddr;
	logic [39:0]     pf_wdata;
	logic [SL_W-1:0] pf_raddr;
	logic [39:0]     pf_rdata;
	logic [39:0]     pf_val;
	logic            ta_we;
	logic [39:0]     ta_wdata;
	logic [RA_W-1:0] ta_raddr;
	logic [39:0]     ta_rdata;

	// Divider port.
	logic        div_start;
	logic [31:0] div_num;
	logic        div_done;
	logic [31:0] div_quot;

	// Combinational helpers.
	logic            accept;
	logic [15:0]     cp_eff;
	logic [8:0]      readers_eff;
	logic            rid_ok;
	logic            table_full;
	logic            skip_bad;
	logic [30:0]     app_pages;
	logic [SL_W:0]   mid_sum;
	logic [SL_W-1:0] mid;
	logic [46:0]     prod;
	logic [30:0]     diff;
	logic [15:0]     cnt_c;
	logic [40:0]     tally_sum;
	logic [39:0]     tally_new;
	logic [30:0]     start_sat;
	logic [39:0]     span;
	logic [39:0]     full;
	logic [39:0]     target;
	logic [39:0]     new_prefix;
	logic            out_free;
	logic [SL_W-1:0] sk_idx;
	pcwd_pkg::rsp_t  res_init;
	pcwd_pkg::rsp_t  rsp_next;

	assign accept    = req_valid && req_ready;
	assign req_ready = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// A chunk size of zero behaves as the reset size; the reader count is
	// clamped into the range that the tally memory covers.
	assign cp_eff = chunk_pages_q == '0 ? pcwd_pkg::CHUNK_PAGES_RESET : chunk_pages_q;

	always_comb begin
		if (reader_count_q == '0) begin
			readers_eff = 9'd1;
		end else if (9'(reader_count_q) > 9'(MAX_READERS)) begin
			readers_eff = 9'(MAX_READERS);
		end else begin
			readers_eff = 9'(reader_count_q);
		end
	end

	assign rid_ok     = {1'b0, req.reader_sel} < readers_eff;
	assign table_full = seq_loaded_q == SL_W'(MAX_SEQS);
	assign skip_bad   = {1'b0, req.seq_index} >= 9'(seq_loaded_q) || req.run_last_page[31];
	assign app_pages  = req.seq_page_count[31] ? '0 : req.seq_page_count[30:0];
	assign sk_idx     = SL_W'(req_q.seq_index);

	// Response fields of a request that ends right away; everything else
	// starts at zero and is filled in as the request proceeds.
	always_comb begin
		res_init = '0;
		case (req.command)
			pcwd_pkg::CMD_APPEND: begin
				if (table_full) begin
					res_init.status = pcwd_pkg::ST_TABLE_FULL;
				end
			end
			pcwd_pkg::CMD_SKIP: begin
				if (skip_bad) begin
					res_init.status = pcwd_pkg::ST_SKIP_IGN;
				end
			end
			default: begin
				if (!rid_ok) begin
					res_init.status = pcwd_pkg::ST_BAD_READER;
				end
			end
		endcase
	end

	// The claimed count reported is the cursor limited to the chunks loaded.
	always_comb begin
		rsp_next               = res_q;
		rsp_next.claimed_total = cursor_q < total_q ? cursor_q : total_q;
	end

	// The divider serves both the chunk count of an append (round up) and
	// the number of fully consumed chunks of a skip.
	assign div_start = accept && ((req.command == pcwd_pkg::CMD_APPEND && !table_full) ||
		(req.command == pcwd_pkg::CMD_SKIP && !skip_bad));
	assign div_num = req.command == pcwd_pkg::CMD_APPEND ?
		{1'b0, app_pages} + {16'd0, cp_eff} - 32'd1 :
		32'(req.run_last_page) + 32'd1;

	// Binary search for the last prefix entry at or below the claimed chunk.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (SL_W + 1)'(1);
	assign mid     = mid_sum[SL_W:1];

	assign pf_val = pf_zero_q ? '0 : pf_rdata;

	assign prod = local_q[30:0] * cp_q;

	always_comb begin
		if (start_q < {17'd0, pages_q}) begin
			diff = pages_q - start_q[30:0];
		end else begin
			diff = '0;
		end
		cnt_c     = diff > {15'd0, cp_q} ? cp_q : diff[15:0];
		start_sat = start_q[47:31] != '0 ? '1 : start_q[30:0];
		tally_sum = {1'b0, tally_q} + {25'd0, cnt_c};
		tally_new = tally_sum[40] ? '1 : tally_sum[39:0];
		span      = p1_q - p0_q;
		full      = {8'd0, div_quot} > span ? span : {8'd0, div_quot};
		target    = p0_q + full;
		new_prefix = total_q + {8'd0, div_quot};
	end

	// Memory port control.
	always_comb begin
		sp_we    = accept && req.command == pcwd_pkg::CMD_APPEND && !table_full;
		sp_waddr = seq_loaded_q[SA_W-1:0];
		sp_wdata = app_pages;
		pf_we    = state_q == S_DIV && div_done && req_q.command == pcwd_pkg::CMD_APPEND;
		pf_waddr = seq_loaded_q + SL_W'(1);
		pf_wdata = new_prefix;
		ta_we    = state_q == S_CNT;
		ta_wdata = tally_new;
		ta_raddr = req.reader_sel[RA_W-1:0];
		case (state_q)
			S_BS_ISSUE: pf_raddr = mid;
			S_SK_A:     pf_raddr = sk_idx;
			S_SK_B:     pf_raddr = sk_idx + SL_W'(1);
			default:    pf_raddr = '0;
		endcase
	end

	pcwd_ram #(.WIDTH(31), .DEPTH(MAX_SEQS)) u_seq_pages (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (lo_q[SA_W-1:0]),
		.rdata (sp_rdata)
	);

	pcwd_ram #(.WIDTH(40), .DEPTH(MAX_SEQS + 1)) u_prefix (
		.clk   (clk),
		.we    (pf_we),
		.waddr (pf_waddr),
		.wdata (pf_wdata),
		.raddr (pf_raddr),
		.rdata (pf_rdata)
	);

	pcwd_ram #(.WIDTH(40), .DEPTH(MAX_READERS)) u_tally (
		.clk   (clk),
		.we    (ta_we),
		.waddr (ra_q),
		.wdata (ta_wdata),
		.raddr (ta_raddr),
		.rdata (ta_rdata)
	);

	pcwd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (cp_eff),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			chunk_pages_q  <= pcwd_pkg::CHUNK_PAGES_RESET;
			reader_count_q <= pcwd_pkg::READER_COUNT_RESET;
			seq_loaded_q   <= '0;
			total_q        <= '0;
			cursor_q       <= '0;
			tvalid_q       <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			pf_zero_q <= pf_raddr == '0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pcwd_pkg::REG_CHUNK_PAGES) begin
					chunk_pages_q <= cfg_data;
				end else if (cfg_index == pcwd_pkg::REG_READER_COUNT) begin
					reader_count_q <= cfg_data[4:0];
				end
			end
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req;
						cp_q  <= cp_eff;
						ra_q  <= req.reader_sel[RA_W-1:0];
						g_q   <= cursor_q;
						res_q <= res_init;
						lo_q  <= '0;
						hi_q  <= seq_loaded_q;
						base_q <= '0;
						case (req.command)
							pcwd_pkg::CMD_APPEND: begin
								if (table_full) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_DIV;
								end
							end
							pcwd_pkg::CMD_SKIP: begin
								if (skip_bad) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_SK_A;
								end
							end
							default: begin
								if (!rid_ok) begin
									state_q <= S_OUT;
								end else begin
									// A claim moves the cursor even when no chunk is left.
									if (req.command == pcwd_pkg::CMD_CLAIM && cursor_q != '1) begin
										cursor_q <= cursor_q + 40'd1;
									end
									state_q <= S_TRD;
								end
							end
						endcase
					end
				end
				S_TRD: begin
					tally_q <= tvalid_q[ra_q] ? ta_rdata : '0;
					res_q.reader_total <= tvalid_q[ra_q] ? ta_rdata : '0;
					if (req_q.command == pcwd_pkg::CMD_QUERY) begin
						state_q <= S_OUT;
					end else if (g_q >= total_q) begin
						res_q.status <= pcwd_pkg::ST_NO_CHUNK;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_BS_ISSUE;
					end
				end
				S_BS_ISSUE: begin
					state_q <= lo_q == hi_q ? S_PG : S_BS_CMP;
				end
				S_BS_CMP: begin
					if (pf_val <= g_q) begin
						lo_q   <= mid;
						base_q <= pf_val;
					end else begin
						hi_q <= mid - SL_W'(1);
					end
					state_q <= S_BS_ISSUE;
				end
				S_PG: begin
					// The sequence page count read is in flight this cycle.
					local_q <= g_q - base_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					pages_q <= sp_rdata;
					start_q <= local_q[39:31] != '0 ? 48'h0000_8000_0000 : {1'b0, prod};
					state_q <= S_CNT;
				end
				S_CNT: begin
					tvalid_q[ra_q]     <= 1'b1;
					res_q.chunk_seq    <= 6'(lo_q);
					res_q.chunk_start  <= start_sat;
					res_q.chunk_count  <= cnt_c;
					res_q.reader_total <= tally_new;
					state_q            <= S_OUT;
				end
				S_SK_A: begin
					state_q <= S_SK_B;
				end
				S_SK_B: begin
					p0_q    <= pf_val;
					state_q <= S_SK_C;
				end
				S_SK_C: begin
					p1_q    <= pf_val;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (req_q.command == pcwd_pkg::CMD_APPEND) begin
							total_q      <= new_prefix;
							seq_loaded_q <= seq_loaded_q + SL_W'(1);
						end else if (target > cursor_q) begin
							cursor_q <= target;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_q   <= rsp_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/pcwd_ram.sv]
// ----------------------------------------------------------------------------
// pcwd_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pcwd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/pcwd_div.sv]
// ----------------------------------------------------------------------------
// pcwd_div: 32 by 16 bit unsigned restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is valid.
// ----------------------------------------------------------------------------
module pcwd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [31:0] quot
);

	logic [31:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic        fits;

	assign rem_sh  = {rem_q, num_q[31]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, so 16 bits always hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
			num_q <= {num_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule
